// ===== sv/rrss_pkg.sv =====
// ----------------------------------------------------------------------------
// rrss_pkg: shared types and constants of the round-robin schedule simulator
// Holds the channel payloads, the per-process record and the ALU opcodes.
// ----------------------------------------------------------------------------
package rrss_pkg;

   localparam int TIME_W  = 17;
   localparam int ARR_W   = 16;
   localparam int BURST_W = 10;
   localparam int TOTAL_W = 15;
   localparam int ID_W    = 6;

   // register byte address of the time slice
   localparam logic [2:0] CSR_QUANTUM_ADDR = 3'd0;
   localparam logic [9:0] QUANTUM_RESET    = 10'd3;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic [BURST_W-1:0] burst_time;
      logic [ARR_W-1:0]   arrival_time;
      logic               last_process;
   } req_data_type;

   typedef struct packed {
      logic [ID_W-1:0]    process_id;
      logic [ARR_W-1:0]   out_arrival;
      logic [TIME_W-1:0]  start_time;
      logic [TIME_W-1:0]  finish_time;
      logic [BURST_W-1:0] out_burst;
      logic [TIME_W-1:0]  wait_time;
      logic [TIME_W-1:0]  turnaround_time;
      logic [TIME_W-1:0]  response_time;
      logic [TOTAL_W-1:0] total_burst;
      logic [TIME_W-1:0]  makespan;
      logic               last_result;
   } rsp_data_type;

   // one process record, indexed by process number
   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] remain;
      logic [TIME_W-1:0]  start;
   } proc_rec_type;

endpackage

// ===== sv/rrss_ram.sv =====
// ----------------------------------------------------------------------------
// rrss_ram: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

// ===== sv/rrss_alu.sv =====
// ----------------------------------------------------------------------------
// rrss_alu: shared time arithmetic unit
// One 17-bit adder/subtractor used by the slice and completion steps of the schedule sequencer.
// ----------------------------------------------------------------------------
module rrss_alu (
   input  rrss_pkg::alu_op_type             op,
   input  logic [rrss_pkg::TIME_W-1:0]      a,
   input  logic [rrss_pkg::TIME_W-1:0]      b,
   output logic [rrss_pkg::TIME_W-1:0]      result
);

   // wraps modulo 2^17
   always_comb begin
      case (op)
         rrss_pkg::ALU_ADD: result = a + b;
         rrss_pkg::ALU_SUB: result = a - b;
         default:           result = a;
      endcase
   end

endmodule

// ===== sv/round_robin_schedule_simulator.sv =====
// ----------------------------------------------------------------------------
// round_robin_schedule_simulator: round-robin processor scheduling engine
// Loads process records, then replays a round-robin schedule and reports
// one completion result per process.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one process record per transfer (burst, arrival, last flag).
//   Records are numbered from 1 in input order; records beyond MAX_PROCS are
//   dropped but their last flag still starts the run.
//   Each record holds the input while it is inserted into the arrival-sorted
//   list, one step per stored record with a later arrival, each step one
//   read and one write of the sort memory.
//   After the record marked last, the sequencer runs the schedule; req_stall
//   stays high until the final result has been loaded into the output
//   register. A turn reads the sort entry and the record and runs one
//   slice; a completion then works out its figures in turn on the single
//   shared adder and may wait for the output register.
//   rsp_* delivers results in completion order from an output register; the
//   final one has last_result set. While rsp_stall is high with a result
//   held, the sequencer waits with the next result and the payload holds.
//   The quantum register sits at byte address 0 of the APB port (reset 3,
//   0 acts as 1). Synchronous reset returns to loading with no records.
// ----------------------------------------------------------------------------
module round_robin_schedule_simulator #(
   parameter int MAX_PROCS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rrss_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrss_pkg::rsp_data_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int SW = rrss_pkg::ARR_W + IW;
   localparam int RW = $bits(rrss_pkg::proc_rec_type);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PROCS);

   typedef enum logic [3:0] {
      S_IDLE, S_INS, S_INSW, S_RINIT, S_RINITW, S_TOP, S_TOPW,
      S_PICK, S_PICKW, S_EXEC, S_TAT, S_WAIT, S_RESP, S_EMIT
   } state_type;

   state_type st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in, k_ff, k_in, ptr_ff, ptr_in;
   logic [CW-1:0] adm_ff, adm_in, done_ff, done_in;
   logic [rrss_pkg::ARR_W-1:0] new_arr_ff, new_arr_in;
   logic new_last_ff, new_last_in;
   logic [rrss_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [9:0] quant_ff;
   logic [rrss_pkg::TIME_W-1:0] time_ff, time_in, mksp_ff, mksp_in;
   logic [rrss_pkg::TIME_W-1:0] tat_ff, tat_in, wait_ff, wait_in, resp_ff, resp_in;
   logic [rrss_pkg::TIME_W-1:0] stt_ff, stt_in;
   logic [IW-1:0] id_ff, id_in;
   logic [MAX_PROCS-1:0] started_ff, started_in, fin_ff, fin_in;
   rrss_pkg::proc_rec_type ent_ff, ent_in;
   logic rsp_valid_ff, rsp_valid_in;
   rrss_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   // memory ports
   logic sort_we, rec_we;
   logic [IW-1:0] sort_waddr, sort_raddr, rec_waddr, rec_raddr;
   logic [SW-1:0] sort_wdata, sort_rdata;
   rrss_pkg::proc_rec_type rec_wdata, rec_rdata;
   logic [RW-1:0] rec_rdata_raw;

   // shared adder
   rrss_pkg::alu_op_type alu_op;
   logic [rrss_pkg::TIME_W-1:0] alu_a, alu_b, alu_y;

   logic [9:0] q_eff;
   logic [rrss_pkg::ARR_W-1:0] rd_arr;
   logic [IW-1:0] rd_id;
   logic [CW-1:0] pick;
   logic [rrss_pkg::TIME_W-1:0] arr_ext;
   logic jump;
   logic cfg_wr;

   rrss_ram #(.WIDTH(SW), .DEPTH(MAX_PROCS), .AW(IW)) u_sort (
      .clock(clock), .we(sort_we), .waddr(sort_waddr), .wdata(sort_wdata),
      .raddr(sort_raddr), .rdata(sort_rdata)
   );

   rrss_ram #(.WIDTH(RW), .DEPTH(MAX_PROCS), .AW(IW)) u_rec (
      .clock(clock), .we(rec_we), .waddr(rec_waddr), .wdata(RW'(rec_wdata)),
      .raddr(rec_raddr), .rdata(rec_rdata_raw)
   );

   rrss_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .result(alu_y));

   assign rec_rdata = rrss_pkg::proc_rec_type'(rec_rdata_raw);
   assign rd_arr    = sort_rdata[SW-1:IW];
   assign rd_id     = sort_rdata[IW-1:0];
   assign arr_ext   = {1'b0, rd_arr};
   assign q_eff     = (quant_ff == 10'd0) ? 10'd1 : quant_ff;

   // configuration port
   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr == rrss_pkg::CSR_QUANTUM_ADDR) ? {22'd0, quant_ff} : 32'd0;

   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer next state
   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; k_in = k_ff; ptr_in = ptr_ff;
      adm_in = adm_ff; done_in = done_ff; new_arr_in = new_arr_ff;
      new_last_in = new_last_ff; total_in = total_ff; time_in = time_ff;
      mksp_in = mksp_ff; tat_in = tat_ff; wait_in = wait_ff; resp_in = resp_ff;
      stt_in = stt_ff; id_in = id_ff; started_in = started_ff; fin_in = fin_ff;
      ent_in = ent_ff; rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sort_we = 1'b0; sort_waddr = '0; sort_wdata = '0; sort_raddr = '0;
      rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0; rec_raddr = '0;
      alu_op = rrss_pkg::ALU_ADD; alu_a = time_ff; alu_b = '0;
      jump = 1'b0; pick = '0;

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               new_arr_in  = req_data.arrival_time;
               new_last_in = req_data.last_process;
               if (cnt_ff < MAX_CNT) begin
                  rec_we    = 1'b1;
                  rec_waddr = cnt_ff[IW-1:0];
                  rec_wdata = '{arrival: req_data.arrival_time,
                                burst:   req_data.burst_time,
                                remain:  req_data.burst_time,
                                start:   '0};
                  total_in  = total_ff + rrss_pkg::TOTAL_W'(req_data.burst_time);
                  k_in      = cnt_ff;
                  st_in     = S_INS;
               end else if (req_data.last_process) begin
                  st_in = S_RINIT;
               end
            end
         end
         // insertion: shift later arrivals up one slot
         S_INS: begin
            if (k_ff == '0) begin
               sort_we    = 1'b1;
               sort_waddr = '0;
               sort_wdata = {new_arr_ff, cnt_ff[IW-1:0]};
               cnt_in     = cnt_ff + 1'b1;
               st_in      = new_last_ff ? S_RINIT : S_IDLE;
            end else begin
               sort_raddr = IW'(k_ff - 1'b1);
               st_in      = S_INSW;
            end
         end
         S_INSW: begin
            sort_we    = 1'b1;
            sort_waddr = k_ff[IW-1:0];
            if (rd_arr > new_arr_ff) begin
               sort_wdata = sort_rdata;
               k_in       = k_ff - 1'b1;
               st_in      = S_INS;
            end else begin
               sort_wdata = {new_arr_ff, cnt_ff[IW-1:0]};
               cnt_in     = cnt_ff + 1'b1;
               st_in      = new_last_ff ? S_RINIT : S_IDLE;
            end
         end
         S_RINIT: begin
            sort_raddr = '0;
            started_in = '0;
            fin_in     = '0;
            ptr_in     = '0;
            adm_in     = '0;
            done_in    = '0;
            st_in      = S_RINITW;
         end
         S_RINITW: begin
            time_in = arr_ext;
            st_in   = S_TOP;
         end
         // admission of arrived processes; with none pending, the clock jumps to the next arrival
         S_TOP: begin
            if (adm_ff == cnt_ff) begin
               st_in = S_PICK;
            end else begin
               sort_raddr = adm_ff[IW-1:0];
               st_in      = S_TOPW;
            end
         end
         S_TOPW: begin
            jump = (done_ff == adm_ff) && (arr_ext > time_ff);
            if (jump) begin
               time_in = arr_ext;
            end
            if (jump || (arr_ext <= time_ff)) begin
               adm_in = adm_ff + 1'b1;
               st_in  = S_TOP;
            end else begin
               st_in = S_PICK;
            end
         end
         // turn pointer
         S_PICK: begin
            pick       = (ptr_ff >= adm_ff) ? '0 : ptr_ff;
            sort_raddr = pick[IW-1:0];
            ptr_in     = pick + 1'b1;
            st_in      = S_PICKW;
         end
         S_PICKW: begin
            id_in     = rd_id;
            rec_raddr = rd_id;
            st_in     = fin_ff[rd_id] ? S_TOP : S_EXEC;
         end
         // run one slice
         S_EXEC: begin
            ent_in  = rec_rdata;
            stt_in  = started_ff[id_ff] ? rec_rdata.start : time_ff;
            started_in[id_ff] = 1'b1;
            rec_we    = 1'b1;
            rec_waddr = id_ff;
            rec_wdata = rec_rdata;
            rec_wdata.start = stt_in;
            if (rec_rdata.remain <= q_eff) begin
               alu_b  = rrss_pkg::TIME_W'(rec_rdata.remain);
               rec_wdata.remain = '0;
               fin_in[id_ff] = 1'b1;
               done_in = done_ff + 1'b1;
               st_in   = S_TAT;
            end else begin
               alu_b  = rrss_pkg::TIME_W'(q_eff);
               rec_wdata.remain = rec_rdata.remain - q_eff;
               st_in  = S_TOP;
            end
            time_in = alu_y;
         end
         // completion figures, one per cycle on the shared adder
         S_TAT: begin
            alu_op = rrss_pkg::ALU_SUB;
            alu_b  = {1'b0, ent_ff.arrival};
            tat_in = alu_y;
            if (time_ff > mksp_ff) begin
               mksp_in = time_ff;
            end
            st_in = S_WAIT;
         end
         S_WAIT: begin
            alu_op  = rrss_pkg::ALU_SUB;
            alu_a   = tat_ff;
            alu_b   = rrss_pkg::TIME_W'(ent_ff.burst);
            wait_in = alu_y;
            st_in   = S_RESP;
         end
         S_RESP: begin
            alu_op  = rrss_pkg::ALU_SUB;
            alu_a   = stt_ff;
            alu_b   = {1'b0, ent_ff.arrival};
            resp_in = alu_y;
            st_in   = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.process_id      = rrss_pkg::ID_W'(id_ff) + 1'b1;
               rsp_data_in.out_arrival     = ent_ff.arrival;
               rsp_data_in.start_time      = stt_ff;
               rsp_data_in.finish_time     = time_ff;
               rsp_data_in.out_burst       = ent_ff.burst;
               rsp_data_in.wait_time       = wait_ff;
               rsp_data_in.turnaround_time = tat_ff;
               rsp_data_in.response_time   = resp_ff;
               rsp_data_in.total_burst     = '0;
               rsp_data_in.makespan        = '0;
               rsp_data_in.last_result     = 1'b0;
               if (done_ff == cnt_ff) begin
                  rsp_data_in.total_burst = total_ff;
                  rsp_data_in.makespan    = mksp_ff;
                  rsp_data_in.last_result = 1'b1;
                  cnt_in   = '0;
                  time_in  = '0;
                  ptr_in   = '0;
                  adm_in   = '0;
                  done_in  = '0;
                  total_in = '0;
                  mksp_in  = '0;
                  st_in    = S_IDLE;
               end else begin
                  st_in = S_TOP;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         ptr_ff       <= '0;
         adm_ff       <= '0;
         done_ff      <= '0;
         new_last_ff  <= 1'b0;
         total_ff     <= '0;
         time_ff      <= '0;
         mksp_ff      <= '0;
         started_ff   <= '0;
         fin_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         quant_ff     <= rrss_pkg::QUANTUM_RESET;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         ptr_ff       <= ptr_in;
         adm_ff       <= adm_in;
         done_ff      <= done_in;
         new_last_ff  <= new_last_in;
         total_ff     <= total_in;
         time_ff      <= time_in;
         mksp_ff      <= mksp_in;
         started_ff   <= started_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr && (paddr == rrss_pkg::CSR_QUANTUM_ADDR)) begin
            quant_ff <= pwdata[9:0];
         end
      end
      new_arr_ff  <= new_arr_in;
      tat_ff      <= tat_in;
      wait_ff     <= wait_in;
      resp_ff     <= resp_in;
      stt_ff      <= stt_in;
      id_ff       <= id_in;
      ent_ff      <= ent_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
